### src/apd_pkg.sv
// ----------------------------------------------------------------------------
// apd_pkg: shared types and arithmetic for the antenna pattern derivatives
// Holds the fixed-point widths, the register map, the structs that pass the
// register file and the precomputed geometry between modules, and the
// rounding, saturating and multiplying functions used by the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package apd_pkg;

  localparam int unsigned DATA_W        = 16;  // Q2.14 inputs and coefficients
  localparam int unsigned INT_W         = 32;  // internal saturated values
  localparam int unsigned PROD_W        = 2 * INT_W;
  localparam int unsigned WIDE_W        = PROD_W + 2;
  localparam int unsigned SUM_W         = 40;  // output sums before clamping
  localparam int unsigned OUT_W         = 20;  // Q6.14 results
  localparam int unsigned CFG_IDX_W     = 4;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned FRAC_BITS_DEF = 14;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [INT_W-1:0]  int_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [OUT_W-1:0]  res_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_ONE_TWO    = 4'd0,
    REG_COEF_THREE_FOUR = 4'd1,
    REG_COEF_FIVE_SIX   = 4'd2,
    REG_COEF_SEVEN_EIGHT = 4'd3,
    REG_COEF_NINE       = 4'd4,
    REG_ALPHA_TRIG      = 4'd5,
    REG_DELTA_TRIG      = 4'd6,
    REG_DETECTOR_PHASE  = 4'd7
  } cfg_reg_t;

  // Register file contents, one signed Q2.14 field per quantity.
  typedef struct packed {
    data_t c1;
    data_t c2;
    data_t c3;
    data_t c4;
    data_t c5;
    data_t c6;
    data_t c7;
    data_t c8;
    data_t c9;
    data_t sa;
    data_t ca;
    data_t sd;
    data_t cd;
    data_t cp;
    data_t sp;
  } apd_regs_t;

  // Terms that depend only on the register file.
  typedef struct packed {
    int_t cosr;
    int_t sinr;
    int_t k6cd;
    int_t k7cd;
    int_t k8sd;
    int_t k9sd;
    int_t k6sd;
    int_t k7sd;
    int_t k8cd;
    int_t k9cd;
    int_t k1csd;
    int_t k2csd;
    int_t k3csd;
    int_t k4csd;
    int_t kc15;
    int_t dd;
    int_t k1tm;
    int_t k2tm;
  } apd_geom_t;

  // Clamp a wide value to the signed 32-bit range.
  function automatic int_t sat32(input wide_t x);
    if ((&x[WIDE_W-1:INT_W-1]) || !(|x[WIDE_W-1:INT_W-1])) begin
      return x[INT_W-1:0];
    end
    return x[WIDE_W-1] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
  endfunction

  // Clamp an output sum to the signed 20-bit range.
  function automatic res_t sat20(input sum_t x);
    if ((&x[SUM_W-1:OUT_W-1]) || !(|x[SUM_W-1:OUT_W-1])) begin
      return x[OUT_W-1:0];
    end
    return x[SUM_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  endfunction

  // Round half up by frac bits, then clamp to 32 bits.
  function automatic int_t rnd_sat(input wide_t x, input int unsigned frac);
    wide_t half;
    wide_t y;
    half = wide_t'(1) <<< (frac - 1);
    y    = (x + half) >>> frac;
    return sat32(y);
  endfunction

  // Full-precision product, rounded once.
  function automatic int_t mulr(input int_t a, input int_t b, input int unsigned frac);
    prod_t p;
    p = a * b;
    return rnd_sat(wide_t'(p), frac);
  endfunction

  // a*b plus or minus c*d at full precision, rounded once.
  function automatic int_t rnd_dot(input int_t a, input int_t b, input int_t c,
                                   input int_t d, input logic neg,
                                   input int unsigned frac);
    prod_t p0;
    prod_t p1;
    wide_t s;
    p0 = a * b;
    p1 = c * d;
    s  = neg ? (wide_t'(p0) - wide_t'(p1)) : (wide_t'(p0) + wide_t'(p1));
    return rnd_sat(s, frac);
  endfunction

  function automatic int_t ext(input data_t x);
    return int_t'(x);
  endfunction

endpackage

`default_nettype wire

### src/apd_geom.sv
// ----------------------------------------------------------------------------
// apd_geom: geometry terms derived from the register file
// A free-running three-stage pipeline that turns the coefficients and the
// sky and detector angles into the products the sample path needs.
// ----------------------------------------------------------------------------
`default_nettype none

module apd_geom
  import apd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic      clk,
  input  wire apd_regs_t regs,
  output apd_geom_t      geom
);

  // First stage: straight from the registers.
  int_t cosr_r, sinr_r, c2d_r, s2d_r, csd_r, c1m5_r;
  int_t k6cd_r, k7cd_r, k8sd_r, k9sd_r, k6sd_r, k7sd_r, k8cd_r, k9cd_r;
  // Second stage.
  int_t dd_r, tm_r, k1csd_r, k2csd_r, k3csd_r, k4csd_r, kc15_r;
  // Third stage.
  int_t k1tm_r, k2tm_r;

  always_ff @(posedge clk) begin
    cosr_r <= rnd_dot(ext(regs.ca), ext(regs.cp), ext(regs.sa), ext(regs.sp), 1'b0,
                      FRAC_BITS);
    sinr_r <= rnd_dot(ext(regs.sa), ext(regs.cp), ext(regs.ca), ext(regs.sp), 1'b1,
                      FRAC_BITS);
    c2d_r  <= mulr(ext(regs.cd), ext(regs.cd), FRAC_BITS);
    s2d_r  <= mulr(ext(regs.sd), ext(regs.sd), FRAC_BITS);
    csd_r  <= mulr(ext(regs.sd), ext(regs.cd), FRAC_BITS);
    c1m5_r <= sat32(wide_t'(regs.c1) - wide_t'(regs.c5));
    k6cd_r <= mulr(ext(regs.c6), ext(regs.cd), FRAC_BITS);
    k7cd_r <= mulr(ext(regs.c7), ext(regs.cd), FRAC_BITS);
    k8sd_r <= mulr(ext(regs.c8), ext(regs.sd), FRAC_BITS);
    k9sd_r <= mulr(ext(regs.c9), ext(regs.sd), FRAC_BITS);
    k6sd_r <= mulr(ext(regs.c6), ext(regs.sd), FRAC_BITS);
    k7sd_r <= mulr(ext(regs.c7), ext(regs.sd), FRAC_BITS);
    k8cd_r <= mulr(ext(regs.c8), ext(regs.cd), FRAC_BITS);
    k9cd_r <= mulr(ext(regs.c9), ext(regs.cd), FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    dd_r    <= sat32(wide_t'(c2d_r) - wide_t'(s2d_r));
    tm_r    <= sat32((wide_t'(2) <<< FRAC_BITS) - wide_t'(c2d_r));
    k1csd_r <= mulr(ext(regs.c1), csd_r, FRAC_BITS);
    k2csd_r <= mulr(ext(regs.c2), csd_r, FRAC_BITS);
    k3csd_r <= mulr(ext(regs.c3), csd_r, FRAC_BITS);
    k4csd_r <= mulr(ext(regs.c4), csd_r, FRAC_BITS);
    kc15_r  <= mulr(csd_r, c1m5_r, FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    k1tm_r <= mulr(ext(regs.c1), tm_r, FRAC_BITS);
    k2tm_r <= mulr(ext(regs.c2), tm_r, FRAC_BITS);
  end

  assign geom.cosr  = cosr_r;
  assign geom.sinr  = sinr_r;
  assign geom.k6cd  = k6cd_r;
  assign geom.k7cd  = k7cd_r;
  assign geom.k8sd  = k8sd_r;
  assign geom.k9sd  = k9sd_r;
  assign geom.k6sd  = k6sd_r;
  assign geom.k7sd  = k7sd_r;
  assign geom.k8cd  = k8cd_r;
  assign geom.k9cd  = k9cd_r;
  assign geom.k1csd = k1csd_r;
  assign geom.k2csd = k2csd_r;
  assign geom.k3csd = k3csd_r;
  assign geom.k4csd = k4csd_r;
  assign geom.kc15  = kc15_r;
  assign geom.dd    = dd_r;
  assign geom.k1tm  = k1tm_r;
  assign geom.k2tm  = k2tm_r;

endmodule

`default_nettype wire

### src/antenna_pattern_derivatives.sv
// ----------------------------------------------------------------------------
// antenna_pattern_derivatives: amplitude modulation derivative pipeline
// For each time sample, computes the derivatives of the amplitude modulation
// functions a and b with respect to declination and right ascension.
// ----------------------------------------------------------------------------
// Usage notes.
// Samples arrive on the in_ channel (valid/stall) as the cosine and sine of
// the sidereal modulation phase in Q2.14, plus a segment-end flag. Every
// accepted sample produces exactly one transfer on the out_ channel carrying
// four saturated Q6.14 derivatives and a copy of the flag, in input order.
// The cfg_ channel (valid/ready, always ready) writes the eight registers of
// coefficients and angles; indexes above seven are ignored. Registers may
// only change while no sample is in flight.
// The datapath has five register stages: sample capture, three stages of one
// multiplier level each and a summing stage, so one sample is taken every
// clock for as long as the output is not stalled.
// A stall on out_stall freezes the last stage; earlier stages keep filling
// bubbles, and in_stall rises only when all five stages hold samples while
// the receiver stalls.
// Synchronous reset clears the registers to zero and empties the pipeline.
// Terms that depend only on the registers come from a free-running side
// pipeline whose stages line up with the sample stages that read them.
// ----------------------------------------------------------------------------
`default_nettype none

module antenna_pattern_derivatives
  import apd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // sample input
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [DATA_W-1:0]     in_cos_mod,
  input  wire logic [DATA_W-1:0]     in_sin_mod,
  input  wire logic                  in_last_sample,
  // result output
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [OUT_W-1:0]           out_da_ddelta,
  output logic [OUT_W-1:0]           out_db_ddelta,
  output logic [OUT_W-1:0]           out_da_dalpha,
  output logic [OUT_W-1:0]           out_db_dalpha,
  output logic                       out_last_result,
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned NUM_STG = 5;

  // --------------------------------------------------------------------------
  // Register file. Writes are accepted every cycle.
  // --------------------------------------------------------------------------
  apd_regs_t regs_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEF_ONE_TWO: begin
          regs_r.c1 <= cfg_wdata[15:0];
          regs_r.c2 <= cfg_wdata[31:16];
        end
        REG_COEF_THREE_FOUR: begin
          regs_r.c3 <= cfg_wdata[15:0];
          regs_r.c4 <= cfg_wdata[31:16];
        end
        REG_COEF_FIVE_SIX: begin
          regs_r.c5 <= cfg_wdata[15:0];
          regs_r.c6 <= cfg_wdata[31:16];
        end
        REG_COEF_SEVEN_EIGHT: begin
          regs_r.c7 <= cfg_wdata[15:0];
          regs_r.c8 <= cfg_wdata[31:16];
        end
        REG_COEF_NINE: begin
          regs_r.c9 <= cfg_wdata[15:0];
        end
        REG_ALPHA_TRIG: begin
          regs_r.sa <= cfg_wdata[15:0];
          regs_r.ca <= cfg_wdata[31:16];
        end
        REG_DELTA_TRIG: begin
          regs_r.sd <= cfg_wdata[15:0];
          regs_r.cd <= cfg_wdata[31:16];
        end
        REG_DETECTOR_PHASE: begin
          regs_r.cp <= cfg_wdata[15:0];
          regs_r.sp <= cfg_wdata[31:16];
        end
        default: begin
          // Unmapped index: the write has no effect.
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Register-only terms. After a register write, each term settles before the
  // first sample taken after that write reaches the stage that reads it.
  // --------------------------------------------------------------------------
  apd_geom_t geom;

  apd_geom #(
    .FRAC_BITS (FRAC_BITS)
  ) u_geom (
    .clk  (clk),
    .regs (regs_r),
    .geom (geom)
  );

  // --------------------------------------------------------------------------
  // Pipeline control. A stage loads when it is empty or when the stage after
  // it moves on; the output stage moves on when the receiver does not stall.
  // --------------------------------------------------------------------------
  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] vld_nxt;
  logic [NUM_STG-1:0] en;
  logic [NUM_STG-1:0] lst_r;

  always_comb begin
    en[NUM_STG-1] = !vld_r[NUM_STG-1] || !out_stall;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NUM_STG; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // The segment flag rides along with each sample.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      lst_r[0] <= in_last_sample;
    end
    for (int k = 1; k < NUM_STG; k++) begin
      if (en[k]) begin
        lst_r[k] <= lst_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture the sample.
  // --------------------------------------------------------------------------
  data_t s1_cm_r, s1_sm_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_cm_r <= in_cos_mod;
      s1_sm_r <= in_sin_mod;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: rotate the modulation phase by the combined sky and detector
  // angle to get c and s.
  // --------------------------------------------------------------------------
  int_t s2_c_r, s2_s_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_c_r <= rnd_dot(geom.cosr, ext(s1_cm_r), geom.sinr, ext(s1_sm_r), 1'b0,
                        FRAC_BITS);
      s2_s_r <= rnd_dot(geom.sinr, ext(s1_cm_r), geom.cosr, ext(s1_sm_r), 1'b1,
                        FRAC_BITS);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: quadratic terms in c and s, the inner products with c3 and c4,
  // and the terms that need only one product with c or s.
  // --------------------------------------------------------------------------
  int_t s3_c2s_r, s3_cs_r, s3_dcs_r, s3_c3c_r, s3_c4s_r;
  int_t s3_dbd3_r, s3_dbd4_r, s3_daa3_r, s3_daa4_r, s3_dba3_r, s3_dba4_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_c2s_r  <= sat32(wide_t'(mulr(s2_c_r, s2_c_r, FRAC_BITS)) <<< 1);
      s3_cs_r   <= mulr(s2_c_r, s2_s_r, FRAC_BITS);
      s3_dcs_r  <= rnd_dot(s2_c_r, s2_c_r, s2_s_r, s2_s_r, 1'b1, FRAC_BITS);
      s3_c3c_r  <= mulr(ext(regs_r.c3), s2_c_r, FRAC_BITS);
      s3_c4s_r  <= mulr(ext(regs_r.c4), s2_s_r, FRAC_BITS);
      s3_dbd3_r <= mulr(geom.k8sd, s2_c_r, FRAC_BITS);
      s3_dbd4_r <= mulr(geom.k9sd, s2_s_r, FRAC_BITS);
      s3_daa3_r <= mulr(geom.k3csd, s2_s_r, FRAC_BITS);
      s3_daa4_r <= mulr(geom.k4csd, s2_c_r, FRAC_BITS);
      s3_dba3_r <= mulr(geom.k8cd, s2_s_r, FRAC_BITS);
      s3_dba4_r <= mulr(geom.k9cd, s2_c_r, FRAC_BITS);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: outer products; the single-product terms pass through.
  // --------------------------------------------------------------------------
  int_t s4_dad1_r, s4_dad2_r, s4_dad3_r, s4_dad4_r;
  int_t s4_dbd1_r, s4_dbd2_r, s4_dbd3_r, s4_dbd4_r;
  int_t s4_daa1_r, s4_daa2_r, s4_daa3_r, s4_daa4_r;
  int_t s4_dba1_r, s4_dba2_r, s4_dba3_r, s4_dba4_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_dad1_r <= mulr(geom.k1csd, s3_c2s_r, FRAC_BITS);
      s4_dad2_r <= mulr(geom.k2csd, s3_cs_r, FRAC_BITS);
      s4_dad3_r <= mulr(s3_c3c_r, geom.dd, FRAC_BITS);
      s4_dad4_r <= mulr(s3_c4s_r, geom.dd, FRAC_BITS);
      s4_dbd1_r <= mulr(geom.k6cd, s3_c2s_r, FRAC_BITS);
      s4_dbd2_r <= mulr(geom.k7cd, s3_cs_r, FRAC_BITS);
      s4_dbd3_r <= s3_dbd3_r;
      s4_dbd4_r <= s3_dbd4_r;
      s4_daa1_r <= mulr(geom.k1tm, s3_cs_r, FRAC_BITS);
      s4_daa2_r <= mulr(geom.k2tm, s3_dcs_r, FRAC_BITS);
      s4_daa3_r <= s3_daa3_r;
      s4_daa4_r <= s3_daa4_r;
      s4_dba1_r <= mulr(geom.k6sd, s3_cs_r, FRAC_BITS);
      s4_dba2_r <= mulr(geom.k7sd, s3_dcs_r, FRAC_BITS);
      s4_dba3_r <= s3_dba3_r;
      s4_dba4_r <= s3_dba4_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: weighted sums at full precision, clamped into the output
  // register. This register is what the receiver sees.
  // --------------------------------------------------------------------------
  sum_t da_dd_sum, db_dd_sum, da_da_sum, db_da_sum;
  res_t o_da_dd_r, o_db_dd_r, o_da_da_r, o_db_da_r;

  always_comb begin
    da_dd_sum = (sum_t'(s4_dad1_r) <<< 1) + (sum_t'(s4_dad2_r) <<< 2)
              + sum_t'(s4_dad3_r) + sum_t'(s4_dad4_r) - (sum_t'(geom.kc15) <<< 1);
    db_dd_sum = sum_t'(s4_dbd1_r) + (sum_t'(s4_dbd2_r) <<< 1)
              - sum_t'(s4_dbd3_r) - sum_t'(s4_dbd4_r) - sum_t'(geom.k6cd);
    da_da_sum = (sum_t'(s4_daa2_r) <<< 1) - (sum_t'(s4_daa1_r) <<< 2)
              - sum_t'(s4_daa3_r) + sum_t'(s4_daa4_r);
    db_da_sum = (sum_t'(s4_dba2_r) <<< 1) - (sum_t'(s4_dba1_r) <<< 2)
              - sum_t'(s4_dba3_r) + sum_t'(s4_dba4_r);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      o_da_dd_r <= sat20(da_dd_sum);
      o_db_dd_r <= sat20(db_dd_sum);
      o_da_da_r <= sat20(da_da_sum);
      o_db_da_r <= sat20(db_da_sum);
    end
  end

  assign out_valid       = vld_r[NUM_STG-1];
  assign out_da_ddelta   = o_da_dd_r;
  assign out_db_ddelta   = o_db_dd_r;
  assign out_da_dalpha   = o_da_da_r;
  assign out_db_dalpha   = o_db_da_r;
  assign out_last_result = lst_r[NUM_STG-1];

  // --------------------------------------------------------------------------
  // Checks on the pipeline control.
  // --------------------------------------------------------------------------

  // Back-pressure reaches the input only when every stage is occupied and
  // the receiver is stalling.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&vld_r) && out_stall))
    else $error("input stalled while the pipeline had room");

  // An input transfer always lands in the first stage.
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted sample missing from the first stage");

  // A result leaves the output stage only through a transfer.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

`default_nettype wire
